/* sv/mhdv_pkg.sv */
// Package for the max heap with delete-by-value unit.
// Holds operation, status and cell command codes and the cell command type.
// No dependencies.
package mhdv_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_POP    = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [2:0] CMD_HOLD   = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_POP    = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_SEARCH = 3'd4;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
   } cmd_type;

endpackage

/* sv/mhdv_cell.sv */
// One cell of the sorted value chain: holds one entry, descending order along the chain.
// Takes the previous cell's entry on insert and the next cell's entry on pop and remove.
// Depends on mhdv_pkg.
module mhdv_cell (
   input  logic               clock,
   input  logic               reset,
   input  mhdv_pkg::cmd_type  cmd,
   input  logic signed [31:0] prev_value,
   input  logic               prev_valid,
   input  logic               prev_take,
   input  logic signed [31:0] next_value,
   input  logic               next_valid,
   output logic signed [31:0] value,
   output logic               valid,
   output logic               take,
   output logic               hit
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               hit_ff, hit_in;
   logic               below;

   assign take  = !valid_ff || (cmd.value > value_ff);
   assign below = !(valid_ff && (value_ff > cmd.value));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      hit_in   = hit_ff;
      unique case (cmd.mode)
         mhdv_pkg::CMD_INSERT: begin
            if (take) begin
               if (prev_take) begin
                  value_in = prev_value;
                  valid_in = prev_valid;
               end else begin
                  value_in = cmd.value;
                  valid_in = 1'b1;
               end
            end
         end
         mhdv_pkg::CMD_POP: begin
            value_in = next_value;
            valid_in = next_valid;
         end
         mhdv_pkg::CMD_REMOVE: begin
            if (below) begin
               value_in = next_value;
               valid_in = next_valid;
            end
         end
         mhdv_pkg::CMD_SEARCH: begin
            hit_in = valid_ff && (value_ff == cmd.value);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

/* sv/max_heap_with_delete_by_value_unit.sv */
// Bounded max priority queue: a chain of CAPACITY cells kept in descending order.
// Sequence: insert, pop and unused code 3 words pass through EXEC then DONE, remove through EXEC, APPLY and DONE.
// A new word is accepted only in IDLE, once the control sequencer has registered the last word's response.
// Reset: synchronous; clears all cell valid bits and the count at once, no clearing pass.
// Depends on mhdv_pkg and mhdv_cell.
module max_heap_with_delete_by_value_unit #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // value[31:0]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // max_value[31:0], entry_count[38:32], is_empty[39],
                                   // status[41:40], zero[47:42]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         func_ff, func_in;
   logic signed [31:0] value_ff, value_in;
   logic [1:0]         status_ff, status_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   logic [47:0]        out_data_ff, out_data_in;

   mhdv_pkg::cmd_type  cmd;

   logic signed [31:0] cell_value [CAPACITY];
   logic               cell_valid [CAPACITY];
   logic               cell_take  [CAPACITY];
   logic [CAPACITY-1:0] hit_vec;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [31:0] p_value, n_value;
         logic               p_valid, p_take, n_valid;
         if (i == 0) begin : g_first
            assign p_value = '0;
            assign p_valid = 1'b0;
            assign p_take  = 1'b0;
         end else begin : g_mid
            assign p_value = cell_value[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_take  = cell_take[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign n_value = '0;
            assign n_valid = 1'b0;
         end else begin : g_inner
            assign n_value = cell_value[i+1];
            assign n_valid = cell_valid[i+1];
         end
         mhdv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_value (p_value),
            .prev_valid (p_valid),
            .prev_take  (p_take),
            .next_value (n_value),
            .next_valid (n_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .take       (cell_take[i]),
            .hit        (hit_vec[i])
         );
      end
   endgenerate

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      cmd.mode     = mhdv_pkg::CMD_HOLD;
      cmd.value    = value_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_tuser;
               value_in  = req_tdata;
               status_in = mhdv_pkg::STATUS_OK;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (func_ff)
               mhdv_pkg::FUNC_INSERT: begin
                  if (count_ff < CNT_W'(CAPACITY)) begin
                     cmd.mode = mhdv_pkg::CMD_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     status_in = mhdv_pkg::STATUS_FULL;
                  end
               end
               mhdv_pkg::FUNC_POP: begin
                  if (count_ff != '0) begin
                     cmd.mode = mhdv_pkg::CMD_POP;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     status_in = mhdv_pkg::STATUS_EMPTY;
                  end
               end
               mhdv_pkg::FUNC_REMOVE: begin
                  cmd.mode = mhdv_pkg::CMD_SEARCH;
                  state_in = ST_APPLY;
               end
               default: begin
               end
            endcase
         end
         ST_APPLY: begin
            state_in = ST_DONE;
            if (|hit_vec) begin
               cmd.mode = mhdv_pkg::CMD_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = mhdv_pkg::STATUS_NOT_FOUND;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = {6'd0, status_ff, (count_ff == '0), 7'(count_ff),
                               (cell_valid[0] ? cell_value[0] : 32'sd0)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      func_ff     <= func_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
